// ===== src/biq_pkg.sv =====
`timescale 1ns / 1ps

package biq_pkg;

  // Item codes on the action field.
  localparam logic [1:0] ACT_FILTER = 2'd0;
  localparam logic [1:0] ACT_WRITE  = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  // Coefficient order inside one section.
  localparam logic [2:0] SEL_B0 = 3'd0;
  localparam logic [2:0] SEL_B1 = 3'd1;
  localparam logic [2:0] SEL_B2 = 3'd2;
  localparam logic [2:0] SEL_A1 = 3'd3;
  localparam logic [2:0] SEL_A2 = 3'd4;

  // Coefficients per section and their stored width.
  localparam int NUM_COEF  = 5;
  localparam int COEF_BITS = 32;

  // Delay states: signed words with a fixed number of fraction bits.
  localparam int STATE_BITS = 48;
  localparam int STATE_FRAC = 12;

  typedef logic signed [STATE_BITS-1:0] state_t;
  typedef logic signed [COEF_BITS-1:0]  coef_t;

endpackage

// ===== src/biq_ram.sv =====
`timescale 1ns / 1ps

module biq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/biquad_iir_cascade_core.sv =====
`timescale 1ns / 1ps

// Biquad IIR filter, Direct Form II Transposed, fixed point.
// Input channel (in_valid / in_stall) carries one command per beat: filter a
// sample, write one coefficient, or clear all delay states. The output
// channel (out_valid / out_stall) carries one filtered sample and its clip
// flag for every filter beat; write and clear beats return nothing.
// Write and clear beats leave the input open.
// A filter beat runs on one shared multiplier fed from the coefficient RAM,
// section by section: HP_SECTIONS sections on the high-pass path and only
// the last section on the low-pass path, with in_stall high the whole time.
// The result is registered at the end of the last section's final phase.
// When the receiver stalls, the result waits in the output register; a new
// item is taken meanwhile, and only its final step waits for the register.
// Reset (synchronous) zeroes the delay states and marks every coefficient
// as unwritten, so it reads as zero until loaded.

module biquad_iir_cascade_core #(
  parameter int HP_SECTIONS    = 2,
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 30
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    action,
  input  logic                          path,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic [2:0]                    coef_section,
  input  logic [2:0]                    coef_select,
  input  logic signed [31:0]            coef_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          saturated
);

  localparam int NSEC    = HP_SECTIONS + 1;
  localparam int SEC_W   = $clog2(NSEC);
  localparam int NCOEF   = NSEC * biq_pkg::NUM_COEF;
  localparam int COEF_AW = $clog2(NCOEF);
  localparam int SB      = biq_pkg::STATE_BITS;
  localparam int PROD_W  = biq_pkg::COEF_BITS + SAMPLE_BITS;
  localparam int ACC_W   = ((PROD_W > SB) ? PROD_W : SB) + 2;
  localparam int RND_SH  = COEF_FRAC_BITS - biq_pkg::STATE_FRAC;

  localparam logic signed [ACC_W-1:0] ST_MAX = ACC_W'({1'b0, {(SB-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] ST_MIN = -ST_MAX - ACC_W'(1);
  localparam logic signed [SB:0] Y_MAX =
    (SB+1)'((64'sd1 <<< (SAMPLE_BITS-1)) - 64'sd1);
  localparam logic signed [SB:0] Y_MIN = -Y_MAX - (SB+1)'(1);

  // Sequencer codes.
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  localparam logic [2:0] PH_C0  = 3'd0;
  localparam logic [2:0] PH_C1  = 3'd1;
  localparam logic [2:0] PH_YF  = 3'd2;
  localparam logic [2:0] PH_Y   = 3'd3;
  localparam logic [2:0] PH_MA1 = 3'd4;
  localparam logic [2:0] PH_W1  = 3'd5;
  localparam logic [2:0] PH_W2  = 3'd6;

  // Rounded product in state format, sign-extended to the accumulator.
  function automatic logic signed [ACC_W-1:0] rnd_prod(
    input logic signed [PROD_W-1:0] p
  );
    logic signed [PROD_W-1:0] t;
    t = p + (PROD_W'(1) <<< (RND_SH - 1));
    return ACC_W'(t >>> RND_SH);
  endfunction

  // Clamp an accumulator value to the delay-state width.
  function automatic biq_pkg::state_t sat_state(input logic signed [ACC_W-1:0] v);
    biq_pkg::state_t r;
    if (v > ST_MAX) begin
      r = ST_MAX[SB-1:0];
    end else if (v < ST_MIN) begin
      r = ST_MIN[SB-1:0];
    end else begin
      r = v[SB-1:0];
    end
    return r;
  endfunction

  logic                          state;
  logic [2:0]                    ph;
  logic [SEC_W-1:0]              sec;
  logic                          lp_path;
  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [SAMPLE_BITS-1:0] y;
  logic                          clip;
  logic signed [PROD_W-1:0]      mul;
  biq_pkg::state_t               yf;
  logic signed [ACC_W-1:0]       acc1;
  logic signed [ACC_W-1:0]       acc2;
  biq_pkg::state_t               w1_q [NSEC];
  biq_pkg::state_t               w2_q [NSEC];
  logic [NCOEF-1:0]              coef_ok;
  logic                          rd_ok;

  logic                          accept;
  logic                          wr_en;
  logic [COEF_AW-1:0]            waddr;
  logic [COEF_AW-1:0]            raddr;
  logic [31:0]                   rdata;
  biq_pkg::coef_t                coef;
  logic signed [SAMPLE_BITS-1:0] mul_in;
  logic                          last_sec;
  logic                          out_busy;
  logic signed [SB:0]            y_t;
  logic signed [SB:0]            y_r;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // Coefficient write decode; out-of-range sections and selects are dropped.
  assign wr_en = accept && (action == biq_pkg::ACT_WRITE) &&
                 (int'(coef_section) <= HP_SECTIONS) &&
                 (coef_select <= biq_pkg::SEL_A2);
  assign waddr = COEF_AW'(int'(coef_section) * biq_pkg::NUM_COEF + int'(coef_select));

  // Coefficients are fetched in order b0, b1, b2, a1, a2 during phases 0..4.
  assign raddr = COEF_AW'(int'(sec) * biq_pkg::NUM_COEF +
                          ((ph <= PH_MA1) ? int'(ph) : 0));

  biq_ram #(
    .WIDTH(biq_pkg::COEF_BITS),
    .DEPTH(NCOEF)
  ) u_coef_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(waddr),
    .wdata(coef_value),
    .raddr(raddr),
    .rdata(rdata)
  );

  // An entry never written since reset reads as zero.
  assign coef   = rd_ok ? biq_pkg::coef_t'(rdata) : '0;
  assign mul_in = (ph >= PH_MA1) ? y : x;

  assign last_sec = lp_path ? (int'(sec) == HP_SECTIONS)
                            : (int'(sec) == HP_SECTIONS - 1);
  assign out_busy = out_valid && out_stall;

  // Section output: round off the fraction bits of yf.
  assign y_t = {yf[SB-1], yf} + ((SB+1)'(1) <<< (biq_pkg::STATE_FRAC - 1));
  assign y_r = y_t >>> biq_pkg::STATE_FRAC;

  // Coefficient valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_ok <= '0;
      rd_ok   <= 1'b0;
    end else begin
      if (wr_en) begin
        coef_ok[waddr] <= 1'b1;
      end
      rd_ok <= coef_ok[raddr];
    end
  end

  // Sequencer and shared multiply-accumulate.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      ph      <= PH_C0;
      sec     <= '0;
      lp_path <= 1'b0;
      clip    <= 1'b0;
      for (int i = 0; i < NSEC; i++) begin
        w1_q[i] <= '0;
        w2_q[i] <= '0;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept && (action == biq_pkg::ACT_CLEAR)) begin
            for (int i = 0; i < NSEC; i++) begin
              w1_q[i] <= '0;
              w2_q[i] <= '0;
            end
          end
          if (accept && (action == biq_pkg::ACT_FILTER)) begin
            state   <= ST_RUN;
            ph      <= PH_C0;
            lp_path <= path;
            sec     <= path ? SEC_W'(HP_SECTIONS) : '0;
            x       <= sample_in;
            clip    <= 1'b0;
          end
        end
        ST_RUN: begin
          // One product per cycle while coefficients stream out of the RAM.
          if ((ph >= PH_C1) && (ph <= PH_W1)) begin
            mul <= PROD_W'(coef) * PROD_W'(mul_in);
          end
          unique case (ph)
            PH_C0, PH_C1: begin
              ph <= ph + 3'd1;
            end
            PH_YF: begin
              yf <= sat_state(rnd_prod(mul) + ACC_W'(w1_q[sec]));
              ph <= PH_Y;
            end
            PH_Y: begin
              acc1 <= rnd_prod(mul) + ACC_W'(w2_q[sec]);
              if (y_r > Y_MAX) begin
                y    <= Y_MAX[SAMPLE_BITS-1:0];
                clip <= 1'b1;
              end else if (y_r < Y_MIN) begin
                y    <= Y_MIN[SAMPLE_BITS-1:0];
                clip <= 1'b1;
              end else begin
                y <= y_r[SAMPLE_BITS-1:0];
              end
              ph <= PH_MA1;
            end
            PH_MA1: begin
              acc2 <= rnd_prod(mul);
              ph   <= PH_W1;
            end
            PH_W1: begin
              w1_q[sec] <= sat_state(acc1 - rnd_prod(mul));
              ph        <= PH_W2;
            end
            PH_W2: begin
              // Writing w2 again while waiting gives the same value.
              w2_q[sec] <= sat_state(acc2 - rnd_prod(mul));
              if (!last_sec) begin
                sec <= sec + SEC_W'(1);
                x   <= y;
                ph  <= PH_C0;
              end else if (!out_busy) begin
                state <= ST_IDLE;
                ph    <= PH_C0;
              end
            end
            default: begin
              ph <= PH_C0;
            end
          endcase
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_RUN) && (ph == PH_W2) && last_sec && !out_busy) begin
      out_valid  <= 1'b1;
      sample_out <= y;
      saturated  <= clip;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== src/biq_chk.sv =====
`timescale 1ns / 1ps

module biq_chk #(
  parameter int SAMPLE_BITS = 24
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [1:0]                    action,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [SAMPLE_BITS-1:0] sample_out,
  input logic                          saturated
);

  // A held result keeps its value until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sample_out) && $stable(saturated))
    else $error("output beat changed while stalled");

  // Reset empties the output register.
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // A filter beat closes the input for the run.
  a_filter_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (action == biq_pkg::ACT_FILTER) |=> in_stall)
    else $error("input open right after a filter beat");

  // Write, clear and unused beats leave the input open.
  a_cmd_quick: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (action != biq_pkg::ACT_FILTER) |=> !in_stall)
    else $error("input closed after a non-filter beat");

  // A new result appears exactly when the run ends.
  a_result_end: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $fell(in_stall))
    else $error("result without end of run");

endmodule

bind biquad_iir_cascade_core biq_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_biq_chk (.*);
